// ===== rtl/kbmc_pkg.sv =====
// Shared types, codes and defaults of the knob/button MIDI CC bridge.
package kbmc_pkg;

    localparam int KNOB_COUNT_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 56;

    // Item kinds
    localparam logic [1:0] OP_KNOB   = 2'd0;
    localparam logic [1:0] OP_SWITCH = 2'd1;
    localparam logic [1:0] OP_RX     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MIDI_CHANNEL = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FOOT_CTL     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LED_CTL      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTROL_MAP  = 3'd3;

    localparam logic [6:0] CC_MAX = 7'd127;
    localparam logic [6:0] CC_MID = 7'd64;

    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  knob_index;
        logic [11:0] sample;
        logic        switch_level;
        logic [3:0]  rx_channel;
        logic        rx_is_control_change;
        logic [6:0]  rx_controller;
        logic [6:0]  rx_value;
    } in_item_t;

    typedef struct packed {
        logic       send_valid;
        logic [3:0] send_channel;
        logic [6:0] send_controller;
        logic [6:0] send_value;
        logic       bypass_on;
        logic       led_on;
    } out_item_t;

endpackage

// ===== rtl/kbmc_knob_mem.sv =====
// Last-reported sample store: one write port, one read port, registered read data.
module kbmc_knob_mem #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 12,
    parameter int ADDR_W = 3
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read-before-write on a same-address collision; the caller forwards.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/knob_button_midi_cc_bridge.sv =====
// Top level of the knob/button to MIDI control-change bridge.
//
// The bridge takes one item per cycle while the result side is not stalled, and returns
// exactly one result item per input item, through the evaluate stage register and then the
// output register. An item is accepted in the cycle that its knob's last reported sample
// is read from a small synchronous memory; the item is then evaluated in the evaluate stage
// (threshold compare, footswitch edge, received CC decode), and when it advances, a reported
// knob's memory entry is written back and the result is loaded into the output register. A
// read that hits a write-back to the same knob is forwarded, so samples may go back to back.
// The memory contents are undefined after reset; per-knob valid bits make an unwritten
// entry read as zero, so there is no clearing pass. Configuration writes are always taken
// (cfg_ready is high) and must be done while no item is in flight.
module knob_button_midi_cc_bridge
    import kbmc_pkg::*;
#(
    parameter int KNOB_COUNT  = KNOB_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_payload,

    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_payload,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int KIDX_W       = (KNOB_COUNT > 1) ? $clog2(KNOB_COUNT) : 1;
    localparam int REPORT_SHIFT = SAMPLE_BITS - 7;
    localparam logic [SAMPLE_BITS-1:0] REPORT_STEP = SAMPLE_BITS'(1) << REPORT_SHIFT;

    // Configuration registers
    logic [3:0]            midi_channel_reg;
    logic [6:0]            foot_ctl_reg;
    logic [6:0]            led_ctl_reg;
    logic [CFG_DATA_W-1:0] control_map_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            midi_channel_reg <= '0;
            foot_ctl_reg     <= '0;
            led_ctl_reg      <= 7'd1;
            control_map_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MIDI_CHANNEL: midi_channel_reg <= cfg_data[3:0];
                CFG_FOOT_CTL:     foot_ctl_reg     <= cfg_data[6:0];
                CFG_LED_CTL:      led_ctl_reg      <= cfg_data[6:0];
                CFG_CONTROL_MAP:  control_map_reg  <= cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    // Evaluate stage and output register
    logic                   st1_valid_reg;
    in_item_t               st1_item_reg;
    logic                   fwd_hit_reg;
    logic [SAMPLE_BITS-1:0] fwd_data_reg;
    logic [KNOB_COUNT-1:0]  kvalid_reg;
    logic                   switch_seen_reg;
    logic                   bypass_reg;
    logic                   led_reg;
    logic                   m_valid_reg;
    out_item_t              m_payload_reg;

    logic                   s_fire;
    logic                   st1_fire;
    logic [KIDX_W-1:0]      rd_idx;
    logic [KIDX_W-1:0]      st1_idx;
    logic [SAMPLE_BITS-1:0] rd_data;
    logic [SAMPLE_BITS-1:0] st1_smp;
    logic [SAMPLE_BITS-1:0] st1_last;
    logic [SAMPLE_BITS-1:0] st1_diff;
    logic                   st1_in_range;
    logic                   mem_we;
    logic                   switch_seen_next;
    logic                   bypass_next;
    logic                   led_next;
    out_item_t              m_payload_next;

    assign st1_fire = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !st1_valid_reg || st1_fire;
    assign s_fire   = s_valid && s_ready;

    assign rd_idx  = s_payload.knob_index[KIDX_W-1:0];
    assign st1_idx = st1_item_reg.knob_index[KIDX_W-1:0];

    kbmc_knob_mem #(
        .DEPTH  (KNOB_COUNT),
        .WIDTH  (SAMPLE_BITS),
        .ADDR_W (KIDX_W)
    ) u_knob_mem (
        .aclk    (aclk),
        .rd_en   (s_fire),
        .rd_addr (rd_idx),
        .rd_data (rd_data),
        .wr_en   (mem_we),
        .wr_addr (st1_idx),
        .wr_data (st1_smp)
    );

    always_comb begin
        st1_smp      = SAMPLE_BITS'(st1_item_reg.sample);
        st1_in_range = {1'b0, st1_item_reg.knob_index} < 4'(KNOB_COUNT);
        // Forward a write-back that collided with this item's read; unwritten reads as zero.
        if (fwd_hit_reg) begin
            st1_last = fwd_data_reg;
        end else if (kvalid_reg[st1_idx]) begin
            st1_last = rd_data;
        end else begin
            st1_last = '0;
        end
        st1_diff = (st1_smp >= st1_last) ? (st1_smp - st1_last) : (st1_last - st1_smp);

        mem_we           = 1'b0;
        switch_seen_next = switch_seen_reg;
        bypass_next      = bypass_reg;
        led_next         = led_reg;
        m_payload_next   = '0;

        case (st1_item_reg.op)
            OP_KNOB: begin
                if (st1_in_range && (st1_diff > REPORT_STEP)) begin
                    mem_we                         = st1_fire;
                    m_payload_next.send_valid      = 1'b1;
                    m_payload_next.send_channel    = midi_channel_reg;
                    m_payload_next.send_controller =
                        control_map_reg[7*st1_item_reg.knob_index +: 7];
                    // Sample below 2^SAMPLE_BITS keeps the shifted value within 7 bits.
                    m_payload_next.send_value      = 7'(st1_smp >> REPORT_SHIFT);
                end
            end
            OP_SWITCH: begin
                if (st1_item_reg.switch_level != switch_seen_reg) begin
                    switch_seen_next               = st1_item_reg.switch_level;
                    m_payload_next.send_valid      = 1'b1;
                    m_payload_next.send_channel    = midi_channel_reg;
                    m_payload_next.send_controller = foot_ctl_reg;
                    m_payload_next.send_value      = st1_item_reg.switch_level ? CC_MAX : '0;
                end
            end
            OP_RX: begin
                if (st1_item_reg.rx_is_control_change &&
                    (st1_item_reg.rx_channel == midi_channel_reg)) begin
                    // Bypass meaning wins when both controllers are equal.
                    if (st1_item_reg.rx_controller == foot_ctl_reg) begin
                        bypass_next = st1_item_reg.rx_value < CC_MID;
                    end else if (st1_item_reg.rx_controller == led_ctl_reg) begin
                        led_next = st1_item_reg.rx_value > CC_MID;
                    end
                end
            end
            default: ;  // unused op: nothing sent, state held
        endcase

        m_payload_next.bypass_on = bypass_next;
        m_payload_next.led_on    = led_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg   <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            kvalid_reg      <= '0;
            switch_seen_reg <= 1'b0;
            bypass_reg      <= 1'b1;
            led_reg         <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (s_fire) begin
                st1_valid_reg <= 1'b1;
                fwd_hit_reg   <= mem_we && (rd_idx == st1_idx);
            end else if (st1_fire) begin
                st1_valid_reg <= 1'b0;
            end
            if (mem_we) begin
                kvalid_reg[st1_idx] <= 1'b1;
            end
            if (st1_fire) begin
                switch_seen_reg <= switch_seen_next;
                bypass_reg      <= bypass_next;
                led_reg         <= led_next;
                m_valid_reg     <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold unless advanced
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st1_item_reg <= s_payload;
            fwd_data_reg <= st1_smp;
        end
        if (st1_fire) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // Input stalls only behind a full evaluate stage and a blocked output register.
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (st1_valid_reg && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    // A write-back marks its knob entry as written.
    a_wb_marks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |=> kvalid_reg[$past(st1_idx)])
        else $error("knob entry written but not marked valid");

    // A taken result with nothing behind it empties the output register.
    a_output_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !st1_valid_reg) |=> !m_valid)
        else $error("result repeated after transfer");

endmodule

// ===== tb/knob_button_midi_cc_bridge_tb.sv =====
// Self-checking testbench of the knob/button MIDI control-change bridge.
module knob_button_midi_cc_bridge_tb;
    import kbmc_pkg::*;

    // Codes outside the package: the unused item kind and an unused register slot
    localparam logic [1:0]             OP_SPARE      = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_IDX = 3'd5;

    localparam logic [11:0] REPORT_STEP    = 12'd32;   // 1/128 of full scale at 12 bits
    localparam int          DRAIN_PAD      = 8;        // cycles past the last result
    localparam int          WATCHDOG_LIMIT = 2000;     // cycles without any transfer
    localparam int          MAX_REPORTS    = 10;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_payload;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_payload;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Shadow copy of the bridge: registers and per-knob/switch/relay state
    logic [3:0]  cfg_channel;
    logic [6:0]  cfg_foot_ctl;
    logic [6:0]  cfg_led_ctl;
    logic [55:0] cfg_ctl_map;
    logic [11:0] knob_last [8];
    logic        switch_seen;
    logic        bypass_now;
    logic        led_now;

    out_item_t cc_expected_q [$];   // predicted messages, oldest first

    int  mismatches      = 0;
    int  messages_seen   = 0;
    int  hold_off_cycles = 0;   // one long receiver stall, consumed by the sink
    bit  burst_mode      = 1'b0; // both sides stop idling while set

    knob_button_midi_cc_bridge dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    //------------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------------

    function automatic void bridge_reset();
        cfg_channel  = 4'd0;
        cfg_foot_ctl = 7'd0;
        cfg_led_ctl  = 7'd1;
        cfg_ctl_map  = '0;
        foreach (knob_last[i]) knob_last[i] = '0;
        switch_seen  = 1'b0;
        bypass_now   = 1'b1;
        led_now      = 1'b0;
    endfunction

    // Advance the shadow state by one item and return the message it causes.
    function automatic out_item_t predict_cc(in_item_t it);
        out_item_t   msg;
        logic [11:0] last;
        logic [11:0] delta;
        int          k;
        msg = '0;
        k   = int'(it.knob_index);
        case (it.op)
            OP_KNOB: begin
                // All eight knob indexes exist, so no index is dropped here.
                last  = knob_last[k];
                delta = (it.sample >= last) ? it.sample - last : last - it.sample;
                // Report only a move strictly beyond one step.
                if (delta > REPORT_STEP) begin
                    knob_last[k]        = it.sample;
                    msg.send_valid      = 1'b1;
                    msg.send_channel    = cfg_channel;
                    msg.send_controller = cfg_ctl_map[7*k +: 7];
                    // sample >> 5 already fits in 7 bits, so no clipping is needed
                    msg.send_value      = it.sample[11:5];
                end
            end
            OP_SWITCH: begin
                if (it.switch_level != switch_seen) begin
                    switch_seen         = it.switch_level;
                    msg.send_valid      = 1'b1;
                    msg.send_channel    = cfg_channel;
                    msg.send_controller = cfg_foot_ctl;
                    msg.send_value      = it.switch_level ? CC_MAX : 7'd0;
                end
            end
            OP_RX: begin
                // Bypass wins when both controller registers match.
                if (it.rx_is_control_change && it.rx_channel == cfg_channel) begin
                    if (it.rx_controller == cfg_foot_ctl)
                        bypass_now = (it.rx_value < CC_MID);
                    else if (it.rx_controller == cfg_led_ctl)
                        led_now = (it.rx_value > CC_MID);
                end
            end
            default: ;  // unused kind: nothing sent, nothing changes
        endcase
        msg.bypass_on = bypass_now;
        msg.led_on    = led_now;
        return msg;
    endfunction

    //------------------------------------------------------------------------
    // Item builders
    //------------------------------------------------------------------------

    // Fill every field with random bits so unused fields toggle as well.
    function automatic in_item_t scrambled();
        in_item_t it;
        it.op                   = 2'($urandom);
        it.knob_index           = 3'($urandom);
        it.sample               = 12'($urandom);
        it.switch_level         = 1'($urandom);
        it.rx_channel           = 4'($urandom);
        it.rx_is_control_change = 1'($urandom);
        it.rx_controller        = 7'($urandom);
        it.rx_value             = 7'($urandom);
        return it;
    endfunction

    function automatic in_item_t knob_item(logic [2:0] k, logic [11:0] smp);
        in_item_t it;
        it            = scrambled();
        it.op         = OP_KNOB;
        it.knob_index = k;
        it.sample     = smp;
        return it;
    endfunction

    function automatic in_item_t switch_item(logic lvl);
        in_item_t it;
        it              = scrambled();
        it.op           = OP_SWITCH;
        it.switch_level = lvl;
        return it;
    endfunction

    function automatic in_item_t rx_item(logic [3:0] ch, logic cc, logic [6:0] ctl,
                                         logic [6:0] val);
        in_item_t it;
        it                      = scrambled();
        it.op                   = OP_RX;
        it.rx_channel           = ch;
        it.rx_is_control_change = cc;
        it.rx_controller        = ctl;
        it.rx_value             = val;
        return it;
    endfunction

    // Mostly well-formed traffic: samples near the report threshold, control
    // changes aimed at this channel and its two controllers, values near 64.
    function automatic in_item_t random_item();
        in_item_t it;
        int       pick;
        int       s;
        it   = scrambled();
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            it.op = OP_KNOB;
            if ($urandom_range(0, 2) != 0) begin
                s = int'(knob_last[it.knob_index]) + int'($urandom_range(0, 70)) - 35;
                if (s < 0)    s = 0;
                if (s > 4095) s = 4095;
                it.sample = 12'(s);
            end
        end else if (pick < 60) begin
            it.op = OP_SWITCH;
        end else if (pick < 95) begin
            it.op = OP_RX;
            if ($urandom_range(0, 4) != 0) begin
                it.rx_channel           = cfg_channel;
                it.rx_is_control_change = 1'b1;
                case ($urandom_range(0, 2))
                    0:       it.rx_controller = cfg_foot_ctl;
                    1:       it.rx_controller = cfg_led_ctl;
                    default: ;
                endcase
                if ($urandom_range(0, 1) != 0)
                    it.rx_value = 7'(int'(CC_MID) + int'($urandom_range(0, 2)) - 1);
            end
        end else begin
            it.op = OP_SPARE;
        end
        return it;
    endfunction

    //------------------------------------------------------------------------
    // Drivers
    //------------------------------------------------------------------------

    // Offer one item after a random gap and hold it until the transfer.
    // Called right after the clock rises; valid stays high from the last item when no gap is drawn.
    task automatic send_item(in_item_t it);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= it;
        do @(posedge aclk); while (!s_ready);
        cc_expected_q.push_back(predict_cc(it));
    endtask

    // Drop valid and hold off until every predicted message has come back.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (cc_expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    // One register write; valid is left high so writes run back to back.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_MIDI_CHANNEL: cfg_channel  = data[3:0];
            CFG_FOOT_CTL:     cfg_foot_ctl = data[6:0];
            CFG_LED_CTL:      cfg_led_ctl  = data[6:0];
            CFG_CONTROL_MAP:  cfg_ctl_map  = data[55:0];
            default: ;
        endcase
    endtask

    // Reprogram every register once the bridge is empty. Upper bits of the
    // narrow registers carry junk, which the bridge must drop.
    task automatic load_config(logic [3:0] ch, logic [6:0] foot, logic [6:0] led,
                               logic [55:0] map);
        logic [CFG_DATA_W-1:0] junk;
        wait_idle();
        junk = CFG_DATA_W'({$urandom, $urandom});
        write_reg(CFG_MIDI_CHANNEL, {junk[55:4], ch});
        write_reg(CFG_FOOT_CTL,     {junk[55:7], foot});
        write_reg(CFG_LED_CTL,      {junk[55:7], led});
        write_reg(CFG_CONTROL_MAP,  map);
        write_reg(CFG_SPARE_IDX,    junk);
        cfg_valid <= 1'b0;
    endtask

    //------------------------------------------------------------------------
    // Result side: random ready, one long hold-off on request
    //------------------------------------------------------------------------

    initial begin : result_sink
        int wait_cycles;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end
            wait_cycles = burst_mode ? 0 : $urandom_range(0, 7);
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic check_field(string name, logic [6:0] want, logic [6:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("message %0d: %s expected %0d, got %0d",
                         messages_seen, name, want, got);
        end
    endtask

    // Compare each message transfer with the oldest prediction.
    always @(posedge aclk) begin : cc_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (cc_expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("message %0d: unexpected transfer %h", messages_seen, m_payload);
            end else begin
                want = cc_expected_q.pop_front();
                check_field("send_valid",      7'(want.send_valid),  7'(m_payload.send_valid));
                check_field("send_channel",    7'(want.send_channel), 7'(m_payload.send_channel));
                check_field("send_controller", want.send_controller, m_payload.send_controller);
                check_field("send_value",      want.send_value,      m_payload.send_value);
                check_field("bypass_on",       7'(want.bypass_on),   7'(m_payload.bypass_on));
                check_field("led_on",          7'(want.led_on),      7'(m_payload.led_on));
            end
            messages_seen++;
        end
    end

    // End the run when no channel has moved for too long.
    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("knob_button_midi_cc_bridge regression: fail");
        $finish;
    end

    //------------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------------

    // Reset defaults: footswitch controller 0, LED controller 1, channel 0.
    task automatic test_power_up();
        send_item(scrambled() | in_item_t'{op: OP_SPARE, default: '0});
        send_item(rx_item(4'd0, 1'b0, 7'd0, 7'd127));   // not a control change
        send_item(rx_item(4'd9, 1'b1, 7'd0, 7'd127));   // another channel
        send_item(rx_item(4'd0, 1'b1, 7'd0, CC_MID));   // bypass off at 64
        send_item(rx_item(4'd0, 1'b1, 7'd0, 7'd63));    // bypass back on
        send_item(rx_item(4'd0, 1'b1, 7'd1, 7'd65));    // LED on
        send_item(rx_item(4'd0, 1'b1, 7'd1, CC_MID));   // LED off at exactly 64
        send_item(rx_item(4'd0, 1'b1, 7'd55, 7'd0));    // matches neither controller
    endtask

    // Threshold is strict: a move of exactly one step is not reported.
    task automatic test_knob_threshold();
        send_item(knob_item(3'd0, 12'd32));
        send_item(knob_item(3'd0, 12'd33));
        send_item(knob_item(3'd0, 12'd1));
        send_item(knob_item(3'd0, 12'd0));
        send_item(knob_item(3'd7, 12'd4095));
        send_item(knob_item(3'd7, 12'd4063));
        send_item(knob_item(3'd7, 12'd4062));
    endtask

    task automatic test_footswitch();
        send_item(switch_item(1'b0));
        send_item(switch_item(1'b1));
        send_item(switch_item(1'b1));
        send_item(switch_item(1'b0));
    endtask

    // Top-of-range registers; equal controllers put bypass ahead of the LED.
    task automatic test_config_extremes();
        load_config(4'd15, 7'd127, 7'd127, '1);
        send_item(rx_item(4'd15, 1'b1, 7'd127, 7'd127));
        send_item(rx_item(4'd15, 1'b1, 7'd127, 7'd0));
        send_item(knob_item(3'd5, 12'd4095));
        send_item(switch_item(1'b1));
        load_config(4'd0, 7'd0, 7'd0, '0);
        send_item(knob_item(3'd5, 12'd0));
        send_item(switch_item(1'b0));
    endtask

    // Random traffic over several random settings, one phase without idling.
    task automatic test_random_traffic();
        logic [6:0] foot;
        for (int phase = 0; phase < 5; phase++) begin
            foot = 7'($urandom);
            load_config(4'($urandom), foot,
                        ($urandom_range(0, 3) == 0) ? foot : 7'($urandom),
                        56'({$urandom, $urandom}));
            burst_mode = (phase % 3 == 2);
            repeat (100) send_item(random_item());
            burst_mode = 1'b0;
        end
    endtask

    // Stall the receiver while the sender streams, so the input backs up.
    task automatic test_backpressure();
        wait_idle();
        burst_mode      = 1'b1;
        hold_off_cycles = 80;
        repeat (40) send_item(random_item());
        burst_mode = 1'b0;
        wait_idle();
    endtask

    initial begin : main
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_payload = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        bridge_reset();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_power_up();
        test_knob_threshold();
        test_footswitch();
        test_config_extremes();
        test_random_traffic();
        test_backpressure();

        wait_idle();
        if (mismatches == 0 && cc_expected_q.size() == 0)
            $display("knob_button_midi_cc_bridge regression: pass");
        else
            $display("knob_button_midi_cc_bridge regression: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/kbmc_pkg.sv
rtl/kbmc_knob_mem.sv
rtl/knob_button_midi_cc_bridge.sv
tb/knob_button_midi_cc_bridge_tb.sv
